FILE: rtl/nearest_neighbor_waypoint_tour_assert.svh
// Assertion macros used by the waypoint tour back end RTL.
`ifndef NEAREST_NEIGHBOR_WAYPOINT_TOUR_ASSERT_SVH
`define NEAREST_NEIGHBOR_WAYPOINT_TOUR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NNWT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define NNWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/nnwt_pkg.sv
// Shared constants and types for the waypoint tour block.
package nnwt_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int RADIUS_W   = 16;
    localparam int R2_W       = 2 * RADIUS_W;
    localparam int SQ_W       = 2 * COORD_BITS + 1;
    localparam int SUM_W      = SQ_W + 1;
    localparam int DIST_W     = (SUM_W > R2_W) ? SUM_W : R2_W;
    localparam int RAM_W      = 2 * COORD_BITS;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(30);

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_LIST = 3'd1;
    localparam logic [2:0] OP_POS  = 3'd2;
    localparam logic [2:0] OP_TICK = 3'd3;
    localparam logic [2:0] OP_DONE = 3'd4;

    localparam logic KIND_WAYPOINT = 1'b0;
    localparam logic KIND_HOME     = 1'b1;

    typedef struct packed {
        logic [2:0]                   op;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } cmd_t;

endpackage

FILE: rtl/nearest_neighbor_waypoint_tour.sv
// Top level of the greedy nearest-neighbor waypoint tour planner.
// Items carry an operation (add point, list complete, position update, tick, tour done)
// and a coordinate pair in signed 0.1 m units. Up to 64 points are kept in a single RAM.
// Add, list-complete and position items pass through the front queue and take effect
// when the back end accepts them. A tick with a known position sweeps the stored points
// once for visit marking. The first tick that finds the list complete, a position known
// and points stored first builds the tour: each waypoint needs one pass over the stored
// points through a four-stage distance pipeline fed by the RAM read port, and one
// waypoint leaves the output register per pass, so a tour over n unvisited points takes
// n passes. After a build, a tour-done item either replans the same way over the points
// left or returns one return-home result; before a build it is dropped. The front queue
// holds two items, so items can be accepted while the back end is busy or the output is
// stalled. The visit radius register (cfg_data) may be rewritten only while the block is
// idle; it resets to 30.
module nearest_neighbor_waypoint_tour (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [2:0]                             operation,
    input  logic signed [nnwt_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [nnwt_pkg::COORD_BITS-1:0] coord_y,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [nnwt_pkg::RADIUS_W-1:0]          cfg_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   kind,
    output logic signed [nnwt_pkg::COORD_BITS-1:0] waypoint_x,
    output logic signed [nnwt_pkg::COORD_BITS-1:0] waypoint_y,
    output logic                                   last_of_run
);

    logic                          cmd_valid;
    logic                          cmd_ready;
    nnwt_pkg::cmd_t                cmd;
    logic [nnwt_pkg::RADIUS_W-1:0] radius;

    // front: accepts items, drops unknown ops, queues commands
    nnwt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .radius       (radius),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    // back: point store, tour build, visit marking, result register
    nnwt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .radius      (radius),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .waypoint_x  (waypoint_x),
        .waypoint_y  (waypoint_y),
        .last_of_run (last_of_run)
    );

endmodule

FILE: rtl/nnwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nnwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: rtl/nnwt_front.sv
// Front end: input handshake, op classification, command queue, radius register.
module nnwt_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          operation,
    input  logic signed [nnwt_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [nnwt_pkg::COORD_BITS-1:0] coord_y,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nnwt_pkg::RADIUS_W-1:0]       cfg_data,
    output logic [nnwt_pkg::RADIUS_W-1:0]       radius,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output nnwt_pkg::cmd_t                      cmd
);

    logic [nnwt_pkg::RADIUS_W-1:0] radius_reg;
    nnwt_pkg::cmd_t                q_reg [2];
    logic                          wptr_reg;
    logic                          rptr_reg;
    logic [1:0]                    cnt_reg;
    logic                          push;
    logic                          pop;
    logic                          known_op;

    assign cfg_ready = 1'b1;
    assign radius    = radius_reg;
    assign in_ready  = (cnt_reg != 2'd2);
    assign known_op  = operation inside {[nnwt_pkg::OP_ADD:nnwt_pkg::OP_DONE]};
    // unknown codes are consumed here and never reach the back end
    assign push      = in_valid && in_ready && known_op;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rptr_reg];
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= nnwt_pkg::RADIUS_RESET;
            wptr_reg   <= 1'b0;
            rptr_reg   <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                radius_reg <= cfg_data;
            end
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= '{op: operation, x: coord_x, y: coord_y};
        end
    end

endmodule

FILE: rtl/nnwt_back.sv
// Back end: point store, tour builder, visit marking and result register.
`include "nearest_neighbor_waypoint_tour_assert.svh"

module nnwt_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cmd_valid,
    output logic                                   cmd_ready,
    input  nnwt_pkg::cmd_t                         cmd,
    input  logic [nnwt_pkg::RADIUS_W-1:0]          radius,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   kind,
    output logic signed [nnwt_pkg::COORD_BITS-1:0] waypoint_x,
    output logic signed [nnwt_pkg::COORD_BITS-1:0] waypoint_y,
    output logic                                   last_of_run
);

    localparam int CB = nnwt_pkg::COORD_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_RET  = 2'd3;

    logic [1:0]                     state_reg;
    logic [nnwt_pkg::CNT_W-1:0]     count_reg;
    logic [nnwt_pkg::CNT_W-1:0]     unv_reg;
    logic [nnwt_pkg::CNT_W-1:0]     prev_reg;
    logic [nnwt_pkg::CNT_W-1:0]     left_reg;
    logic [nnwt_pkg::CNT_W-1:0]     scan_idx_reg;
    logic [nnwt_pkg::MAX_POINTS-1:0] visited_reg;
    logic [nnwt_pkg::MAX_POINTS-1:0] taken_reg;
    logic                           complete_reg;
    logic                           known_reg;
    logic                           built_reg;
    logic                           mark_pend_reg;
    logic                           mode_build_reg;
    logic                           found_reg;
    logic                           out_valid_reg;
    logic                           va_reg;
    logic                           vb_reg;
    logic                           vc_reg;
    logic [nnwt_pkg::IDX_W-1:0]     ia_reg;
    logic [nnwt_pkg::IDX_W-1:0]     ib_reg;
    logic [nnwt_pkg::IDX_W-1:0]     ic_reg;
    logic [nnwt_pkg::IDX_W-1:0]     best_idx_reg;

    logic signed [CB-1:0]           vx_reg, vy_reg;
    logic signed [CB-1:0]           cx_reg, cy_reg;
    logic signed [CB-1:0]           pxb_reg, pyb_reg, pxc_reg, pyc_reg;
    logic signed [CB:0]             dxb_reg, dyb_reg;
    logic [nnwt_pkg::SQ_W-1:0]      sqx_reg, sqy_reg;
    logic [nnwt_pkg::DIST_W-1:0]    best_dist_reg;
    logic [nnwt_pkg::R2_W-1:0]      r2_reg;
    logic signed [CB-1:0]           best_x_reg, best_y_reg;
    logic                           out_kind_reg, out_last_reg;
    logic signed [CB-1:0]           out_x_reg, out_y_reg;

    logic [nnwt_pkg::RAM_W-1:0]     rdata;
    logic signed [CB-1:0]           rx, ry;
    logic                           ram_we;
    logic [nnwt_pkg::IDX_W-1:0]     scan_addr;
    logic                           issuing;
    logic                           skip;
    logic                           scan_done;
    logic [nnwt_pkg::DIST_W-1:0]    sum_sq;
    logic [nnwt_pkg::DIST_W-1:0]    r2_ext;
    logic                           out_free;
    logic                           start_build;
    logic                           emit_wp;
    logic                           emit_home;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign scan_addr = scan_idx_reg[nnwt_pkg::IDX_W-1:0];
    assign issuing   = (state_reg == ST_SCAN) && (scan_idx_reg < count_reg);
    assign skip      = visited_reg[scan_addr] || (mode_build_reg && taken_reg[scan_addr]);
    assign scan_done = (state_reg == ST_SCAN) && !issuing && !va_reg && !vb_reg && !vc_reg;
    assign sum_sq    = nnwt_pkg::DIST_W'(sqx_reg) + nnwt_pkg::DIST_W'(sqy_reg);
    assign r2_ext    = nnwt_pkg::DIST_W'(r2_reg);
    assign rx        = rdata[nnwt_pkg::RAM_W-1:CB];
    assign ry        = rdata[CB-1:0];
    assign ram_we    = (state_reg == ST_IDLE) && cmd_valid && (cmd.op == nnwt_pkg::OP_ADD)
                       && (count_reg < nnwt_pkg::CNT_W'(nnwt_pkg::MAX_POINTS));
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_wp   = (state_reg == ST_EMIT) && out_free;
    assign emit_home = (state_reg == ST_RET) && out_free;

    // TICK starts a build on the first tick that has everything it needs; DONE starts a replan after a build
    assign start_build = (state_reg == ST_IDLE) && cmd_valid &&
        (((cmd.op == nnwt_pkg::OP_TICK) && !built_reg && complete_reg && known_reg
          && (count_reg != '0)) ||
         ((cmd.op == nnwt_pkg::OP_DONE) && built_reg && (unv_reg != '0)
          && (unv_reg < prev_reg)));

    nnwt_ram #(
        .WIDTH (nnwt_pkg::RAM_W),
        .DEPTH (nnwt_pkg::MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[nnwt_pkg::IDX_W-1:0]),
        .wdata ({cmd.x, cmd.y}),
        .raddr (scan_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            unv_reg        <= '0;
            prev_reg       <= '0;
            left_reg       <= '0;
            scan_idx_reg   <= '0;
            visited_reg    <= '0;
            taken_reg      <= '0;
            complete_reg   <= 1'b0;
            known_reg      <= 1'b0;
            built_reg      <= 1'b0;
            mark_pend_reg  <= 1'b0;
            mode_build_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            va_reg         <= 1'b0;
            vb_reg         <= 1'b0;
            vc_reg         <= 1'b0;
            vx_reg         <= '0;
            vy_reg         <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit_wp && !emit_home)
            begin
                out_valid_reg <= 1'b0;
            end
            va_reg <= issuing && !skip;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            if (issuing)
            begin
                scan_idx_reg <= scan_idx_reg + nnwt_pkg::CNT_W'(1);
            end
            // final scan stage
            if (vc_reg)
            begin
                if (mode_build_reg)
                begin
                    if (!found_reg || (sum_sq < best_dist_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                end
                else if (sum_sq <= r2_ext)
                begin
                    visited_reg[ic_reg] <= 1'b1;
                    unv_reg             <= unv_reg - nnwt_pkg::CNT_W'(1);
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        case (cmd.op)
                            nnwt_pkg::OP_ADD:
                            begin
                                if (ram_we)
                                begin
                                    visited_reg[count_reg[nnwt_pkg::IDX_W-1:0]] <= 1'b0;
                                    count_reg <= count_reg + nnwt_pkg::CNT_W'(1);
                                    unv_reg   <= unv_reg + nnwt_pkg::CNT_W'(1);
                                end
                            end
                            nnwt_pkg::OP_LIST:
                            begin
                                complete_reg <= 1'b1;
                            end
                            nnwt_pkg::OP_POS:
                            begin
                                vx_reg    <= cmd.x;
                                vy_reg    <= cmd.y;
                                known_reg <= 1'b1;
                            end
                            nnwt_pkg::OP_TICK:
                            begin
                                if (start_build)
                                begin
                                    built_reg <= 1'b1;
                                    prev_reg  <= unv_reg;
                                end
                                if (start_build && (unv_reg != '0))
                                begin
                                    // marking follows the build
                                    mark_pend_reg  <= 1'b1;
                                    taken_reg      <= '0;
                                    left_reg       <= unv_reg;
                                    mode_build_reg <= 1'b1;
                                    found_reg      <= 1'b0;
                                    scan_idx_reg   <= '0;
                                    state_reg      <= ST_SCAN;
                                end
                                else if (known_reg)
                                begin
                                    mode_build_reg <= 1'b0;
                                    mark_pend_reg  <= 1'b0;
                                    scan_idx_reg   <= '0;
                                    state_reg      <= ST_SCAN;
                                end
                            end
                            nnwt_pkg::OP_DONE:
                            begin
                                mark_pend_reg <= 1'b0;
                                if (start_build)
                                begin
                                    prev_reg       <= unv_reg;
                                    taken_reg      <= '0;
                                    left_reg       <= unv_reg;
                                    mode_build_reg <= 1'b1;
                                    found_reg      <= 1'b0;
                                    scan_idx_reg   <= '0;
                                    state_reg      <= ST_SCAN;
                                end
                                else if (built_reg)
                                begin
                                    state_reg <= ST_RET;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (scan_done)
                    begin
                        state_reg <= mode_build_reg ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_wp)
                    begin
                        out_valid_reg           <= 1'b1;
                        taken_reg[best_idx_reg] <= 1'b1;
                        left_reg                <= left_reg - nnwt_pkg::CNT_W'(1);
                        found_reg               <= 1'b0;
                        scan_idx_reg            <= '0;
                        if (left_reg != nnwt_pkg::CNT_W'(1))
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else if (mark_pend_reg)
                        begin
                            // tour done, now the tick's visit marking
                            mode_build_reg <= 1'b0;
                            mark_pend_reg  <= 1'b0;
                            state_reg      <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_RET:
                begin
                    if (emit_home)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        r2_reg  <= radius * radius;
        ia_reg  <= scan_addr;
        ib_reg  <= ia_reg;
        ic_reg  <= ib_reg;
        pxb_reg <= rx;
        pyb_reg <= ry;
        dxb_reg <= $signed({rx[CB-1], rx}) - $signed({cx_reg[CB-1], cx_reg});
        dyb_reg <= $signed({ry[CB-1], ry}) - $signed({cy_reg[CB-1], cy_reg});
        pxc_reg <= pxb_reg;
        pyc_reg <= pyb_reg;
        sqx_reg <= nnwt_pkg::SQ_W'(dxb_reg * dxb_reg);
        sqy_reg <= nnwt_pkg::SQ_W'(dyb_reg * dyb_reg);
        if (state_reg == ST_IDLE)
        begin
            cx_reg <= (cmd.op == nnwt_pkg::OP_POS) ? cmd.x : vx_reg;
            cy_reg <= (cmd.op == nnwt_pkg::OP_POS) ? cmd.y : vy_reg;
        end
        else if (emit_wp)
        begin
            cx_reg <= (left_reg != nnwt_pkg::CNT_W'(1)) ? best_x_reg : vx_reg;
            cy_reg <= (left_reg != nnwt_pkg::CNT_W'(1)) ? best_y_reg : vy_reg;
        end
        if (vc_reg && mode_build_reg && (!found_reg || (sum_sq < best_dist_reg)))
        begin
            best_dist_reg <= sum_sq;
            best_idx_reg  <= ic_reg;
            best_x_reg    <= pxc_reg;
            best_y_reg    <= pyc_reg;
        end
        if (emit_wp)
        begin
            out_kind_reg <= nnwt_pkg::KIND_WAYPOINT;
            out_x_reg    <= best_x_reg;
            out_y_reg    <= best_y_reg;
            out_last_reg <= (left_reg == nnwt_pkg::CNT_W'(1));
        end
        else if (emit_home)
        begin
            out_kind_reg <= nnwt_pkg::KIND_HOME;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign waypoint_x  = out_x_reg;
    assign waypoint_y  = out_y_reg;
    assign last_of_run = out_last_reg;

    `NNWT_ASSERT_NOW(a_unv_bound, clk, rst_n, 1'b1, unv_reg <= count_reg,
        "unvisited count exceeds point count")
    `NNWT_ASSERT_NOW(a_built_ok, clk, rst_n, built_reg, complete_reg && known_reg,
        "tour built without list or position")
    `NNWT_ASSERT_NOW(a_emit_left, clk, rst_n, state_reg == ST_EMIT,
        found_reg && (left_reg != '0), "emit without a chosen point")
    `NNWT_ASSERT_NEXT(a_home_out, clk, rst_n, emit_home,
        out_valid_reg && (out_kind_reg == nnwt_pkg::KIND_HOME) && out_last_reg,
        "return home result not presented")

endmodule

FILE: tb/sv/testbench.sv
// Testbench for the nearest-neighbor waypoint tour planner: directed and random items.
`timescale 1ns / 1ps

module testbench;

    localparam int CB    = nnwt_pkg::COORD_BITS;
    localparam int RW    = nnwt_pkg::RADIUS_W;
    localparam int MAXP  = nnwt_pkg::MAX_POINTS;

    // Operation codes the block has no meaning for; it must drop them silently.
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // Worst quiet stretch of a correct block is one pass over 64 points; keep a big margin.
    localparam int WATCHDOG_LIMIT = 20000;
    // Settling time before a register write or the final check: a full sweep plus queue.
    localparam int SETTLE_CYCLES  = 300;

    typedef struct {
        logic                 kind;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 last;
    } waypoint_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [2:0] operation;
    logic signed [CB-1:0] coord_x;
    logic signed [CB-1:0] coord_y;
    logic cfg_valid;
    logic cfg_ready;
    logic [RW-1:0] cfg_data;
    logic out_valid;
    logic out_ready;
    logic kind;
    logic signed [CB-1:0] waypoint_x;
    logic signed [CB-1:0] waypoint_y;
    logic last_of_run;

    nearest_neighbor_waypoint_tour dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .waypoint_x  (waypoint_x),
        .waypoint_y  (waypoint_y),
        .last_of_run (last_of_run)
    );

    // Mirror of the planner state
    logic signed [CB-1:0] pts_x [MAXP];
    logic signed [CB-1:0] pts_y [MAXP];
    logic        pt_visited [MAXP];
    logic        pt_taken   [MAXP];
    int          pt_count;
    logic signed [CB-1:0] veh_x;
    logic signed [CB-1:0] veh_y;
    logic        list_done;
    logic        pos_known;
    logic        tour_built;
    int          prev_unvisited;
    logic [RW-1:0] radius;

    waypoint_t pending_waypoints [$];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Squared distance; deltas fit in 17 bits so 64 bits hold the sum exactly.
    function automatic longint unsigned dist2(logic signed [CB-1:0] ax,
                                              logic signed [CB-1:0] ay,
                                              logic signed [CB-1:0] bx,
                                              logic signed [CB-1:0] by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    function automatic int count_unvisited();
        int n;
        n = 0;
        for (int i = 0; i < pt_count; i++)
            if (!pt_visited[i])
                n++;
        return n;
    endfunction

    function automatic void queue_result(waypoint_t w);
        pending_waypoints = {pending_waypoints, w};
    endfunction

    // Greedy tour from the vehicle over unvisited points; lowest index wins ties.
    function automatic void plan_tour();
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        longint unsigned best_d;
        longint unsigned d;
        int best;
        int n;
        waypoint_t w;
        cx = veh_x;
        cy = veh_y;
        n = 0;
        for (int i = 0; i < MAXP; i++)
            pt_taken[i] = 1'b0;
        forever
        begin
            best = -1;
            best_d = 0;
            for (int i = 0; i < pt_count; i++)
            begin
                if (pt_visited[i] || pt_taken[i])
                    continue;
                d = dist2(pts_x[i], pts_y[i], cx, cy);
                if (best < 0 || d < best_d)
                begin
                    best = i;
                    best_d = d;
                end
            end
            if (best < 0 || n >= MAXP)
                break;
            pt_taken[best] = 1'b1;
            w.kind = nnwt_pkg::KIND_WAYPOINT;
            w.x = pts_x[best];
            w.y = pts_y[best];
            w.last = 1'b0;
            queue_result(w);
            n++;
            cx = pts_x[best];
            cy = pts_y[best];
        end
        if (n > 0)
            pending_waypoints[$].last = 1'b1;
    endfunction

    function automatic void apply_item(logic [2:0] op, logic signed [CB-1:0] x,
                                       logic signed [CB-1:0] y);
        longint unsigned r2;
        int rem;
        waypoint_t w;
        case (op)
            nnwt_pkg::OP_ADD:
            begin
                if (pt_count < MAXP)
                begin
                    pts_x[pt_count] = x;
                    pts_y[pt_count] = y;
                    pt_visited[pt_count] = 1'b0;
                    pt_count++;
                end
            end
            nnwt_pkg::OP_LIST: list_done = 1'b1;
            nnwt_pkg::OP_POS:
            begin
                veh_x = x;
                veh_y = y;
                pos_known = 1'b1;
            end
            nnwt_pkg::OP_TICK:
            begin
                // build once, then visit marking against the current position
                if (!tour_built && list_done && pos_known && pt_count > 0)
                begin
                    plan_tour();
                    tour_built = 1'b1;
                    prev_unvisited = count_unvisited();
                end
                if (pos_known)
                begin
                    r2 = longint'(radius) * longint'(radius);
                    for (int i = 0; i < pt_count; i++)
                        if (!pt_visited[i] && dist2(pts_x[i], pts_y[i], veh_x, veh_y) <= r2)
                            pt_visited[i] = 1'b1;
                end
            end
            nnwt_pkg::OP_DONE:
            begin
                if (tour_built)
                begin
                    rem = count_unvisited();
                    if (rem != 0 && rem < prev_unvisited)
                    begin
                        prev_unvisited = rem;
                        plan_tour();
                    end
                    else
                    begin
                        w.kind = nnwt_pkg::KIND_HOME;
                        w.x = '0;
                        w.y = '0;
                        w.last = 1'b1;
                        queue_result(w);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // One item on the input channel; prediction happens at the accepting edge.
    task automatic send_item(logic [2:0] op, logic signed [CB-1:0] x,
                             logic signed [CB-1:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            operation <= 3'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        coord_x <= x;
        coord_y <= y;
        do
            @(posedge clk);
        while (!in_ready);
        apply_item(op, x, y);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_waypoints.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_radius(logic [RW-1:0] r);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius = r;
    endtask

    function automatic logic signed [CB-1:0] near_coord();
        return CB'($urandom_range(400) - 200);
    endfunction

    // Random item: mostly movement toward stored points and ticks, so points get
    // visited and tour-done items replan; some full-range values and junk codes.
    task automatic random_item(int max_points);
        int sel;
        int idx;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        sel = $urandom_range(99);
        if ($urandom_range(9) == 0)
        begin
            x = CB'($urandom);
            y = CB'($urandom);
        end
        else
        begin
            x = near_coord();
            y = near_coord();
        end
        if (sel < 20)
        begin
            if (pt_count < max_points)
                send_item(nnwt_pkg::OP_ADD, x, y);
            else
                send_item(nnwt_pkg::OP_TICK, x, y);
        end
        else if (sel < 45)
        begin
            if (pt_count > 0 && $urandom_range(1) == 1)
            begin
                // land close to a stored point so the next tick may visit it
                idx = $urandom_range(pt_count - 1);
                x = pts_x[idx] + CB'($urandom_range(20) - 10);
                y = pts_y[idx] + CB'($urandom_range(20) - 10);
            end
            send_item(nnwt_pkg::OP_POS, x, y);
        end
        else if (sel < 75)
            send_item(nnwt_pkg::OP_TICK, x, y);
        else if (sel < 90)
            send_item(nnwt_pkg::OP_DONE, x, y);
        else if (sel < 94)
            send_item(nnwt_pkg::OP_LIST, x, y);
        else
            send_item(3'($urandom_range(OP_RSVD7, OP_RSVD5)), x, y);
    endtask

    // Ignored items, empty-list tick, first build, replan and return home.
    task automatic test_directed();
        send_item(OP_RSVD5, 16'sd1, 16'sd1);
        send_item(OP_RSVD6, -16'sd1, -16'sd1);
        send_item(OP_RSVD7, 16'sh7fff, 16'sh8000);
        send_item(nnwt_pkg::OP_DONE, 16'sd0, 16'sd0);   // before any build: dropped
        send_item(nnwt_pkg::OP_TICK, 16'sd0, 16'sd0);   // position unknown
        send_item(nnwt_pkg::OP_LIST, 16'sd0, 16'sd0);
        send_item(nnwt_pkg::OP_POS, 16'sd0, 16'sd0);
        send_item(nnwt_pkg::OP_TICK, 16'sd0, 16'sd0);   // empty list: no tour
        send_item(nnwt_pkg::OP_ADD, 16'sh8000, 16'sh8000);
        send_item(nnwt_pkg::OP_ADD, 16'sh7fff, 16'sh7fff);
        send_item(nnwt_pkg::OP_ADD, 16'sh7fff, 16'sh8000);
        send_item(nnwt_pkg::OP_ADD, 16'sh8000, 16'sh7fff);
        send_item(nnwt_pkg::OP_ADD, 16'sd5, 16'sd5);
        send_item(nnwt_pkg::OP_ADD, -16'sd5, -16'sd5);  // tie with the previous one
        send_item(nnwt_pkg::OP_ADD, 16'sd5, 16'sd5);    // duplicate
        send_item(nnwt_pkg::OP_ADD, 16'sd100, -16'sd100);
        send_item(nnwt_pkg::OP_TICK, 16'sd0, 16'sd0);   // builds, visits the three near origin
        send_item(nnwt_pkg::OP_DONE, 16'sd0, 16'sd0);   // progress: replan
        send_item(nnwt_pkg::OP_DONE, 16'sd0, 16'sd0);   // no progress: home
        send_item(nnwt_pkg::OP_POS, 16'sd100, -16'sd100);
        send_item(nnwt_pkg::OP_TICK, 16'sd0, 16'sd0);
        send_item(nnwt_pkg::OP_ADD, 16'sd300, 16'sd300); // joins later tours
        send_item(nnwt_pkg::OP_DONE, 16'sd0, 16'sd0);
    endtask

    task automatic test_random(int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            random_item(56);
            if (i == n_items / 2)
                wait_drained();   // hold the sender until every waypoint is out
        end
    endtask

    task automatic test_radius_extremes();
        write_radius(16'd0);
        for (int i = 0; i < 30; i++)
            random_item(56);
        write_radius(16'hffff);
        for (int i = 0; i < 15; i++)
            random_item(56);
    endtask

    // Fill past capacity; extra adds are dropped.
    task automatic test_store_full();
        write_radius(16'd50);
        while (pt_count < MAXP)
            send_item(nnwt_pkg::OP_ADD, near_coord(), near_coord());
        send_item(nnwt_pkg::OP_ADD, 16'sh7fff, 16'sh7fff);
        send_item(nnwt_pkg::OP_ADD, 16'sh8000, 16'sh8000);
        for (int i = 0; i < 20; i++)
            random_item(MAXP);
    endtask

    // Receiver stall pattern, result checking and watchdog.
    always @(posedge clk)
    begin
        waypoint_t w;
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (pending_waypoints.size() == 0)
                begin
                    $error("unexpected result kind=%0d x=%0d y=%0d", kind, waypoint_x,
                           waypoint_y);
                    fail_count++;
                end
                else
                begin
                    w = pending_waypoints.pop_front();
                    if (kind !== w.kind)
                    begin
                        $error("kind: expected %0d actual %0d", w.kind, kind);
                        fail_count++;
                    end
                    if (waypoint_x !== w.x)
                    begin
                        $error("waypoint_x: expected %0d actual %0d", w.x, waypoint_x);
                        fail_count++;
                    end
                    if (waypoint_y !== w.y)
                    begin
                        $error("waypoint_y: expected %0d actual %0d", w.y, waypoint_y);
                        fail_count++;
                    end
                    if (last_of_run !== w.last)
                    begin
                        $error("last_of_run: expected %0d actual %0d", w.last, last_of_run);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = nnwt_pkg::OP_ADD;
        coord_x = '0;
        coord_y = '0;
        cfg_valid = 1'b0;
        cfg_data = nnwt_pkg::RADIUS_RESET;
        out_ready = 1'b0;
        fail_count = 0;
        quiet_cycles = 0;
        pt_count = 0;
        veh_x = '0;
        veh_y = '0;
        list_done = 1'b0;
        pos_known = 1'b0;
        tour_built = 1'b0;
        prev_unvisited = 0;
        radius = nnwt_pkg::RADIUS_RESET;
        for (int i = 0; i < MAXP; i++)
        begin
            pts_x[i] = '0;
            pts_y[i] = '0;
            pt_visited[i] = 1'b0;
            pt_taken[i] = 1'b0;
        end
        send_idle_pct = 18;
        recv_stall_pct = 54;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_radius(16'd30);
        send_idle_pct = 54;
        recv_stall_pct = 18;
        write_radius(16'd120);
        test_random(90);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(40);
        test_radius_extremes();
        test_store_full();

        wait_drained();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
